### rtl/core/cslg_pkg.sv
// Shared types and constants for the cylinder light splat grid.
// Command codes, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package cslg_pkg;

	// command codes
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_CIRC_BINS    = 3'd0;
	localparam logic [2:0] REG_HEIGHT_BINS  = 3'd1;
	localparam logic [2:0] REG_WALL_HEIGHT  = 3'd2;
	localparam logic [2:0] REG_LIGHT_GAIN   = 3'd3;
	localparam logic [2:0] REG_REACH_HEIGHT = 3'd4;
	localparam logic [2:0] REG_REACH_CIRC   = 3'd5;

	localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

	// CORDIC: vector width, angle accumulator width (2^-24 turn units)
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_W     = 36;
	localparam int ANGLE_W      = 26;

	typedef logic [21:0] atan_t;

	// arctan(2^-i) in units of 2^-24 turn
	function automatic atan_t atan_turn(input logic [4:0] i);
		atan_t r;
		unique case (i)
			5'd0:  r = 22'd2097152;
			5'd1:  r = 22'd1238021;
			5'd2:  r = 22'd654136;
			5'd3:  r = 22'd332050;
			5'd4:  r = 22'd166669;
			5'd5:  r = 22'd83416;
			5'd6:  r = 22'd41718;
			5'd7:  r = 22'd20860;
			5'd8:  r = 22'd10430;
			5'd9:  r = 22'd5215;
			5'd10: r = 22'd2608;
			5'd11: r = 22'd1304;
			5'd12: r = 22'd652;
			5'd13: r = 22'd326;
			5'd14: r = 22'd163;
			5'd15: r = 22'd81;
			5'd16: r = 22'd41;
			5'd17: r = 22'd20;
			5'd18: r = 22'd10;
			5'd19: r = 22'd5;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/cylinder_light_splat_grid.sv
// Cylinder light splat grid: CORDIC angle, window walk and saturating store.
// Holds the light store memory, a shared radix-2 divider and the control FSM.
// Depends on cslg_pkg.
//
//  channel   | handshake        | words
//  ----------+------------------+------------------------------------------
//  command   | start / busy     | cmd, pos_x, pos_y, pos_z, cell_addr
//  result    | done (1 cycle)   | cell_value, cells_lit, on_axis
//  config    | cfg_we           | cfg_index, cfg_data
//
// Read: result two cycles after accept. Unknown command or on-axis add: one.
// Add: CORDIC angle and window set-up, then per grid row hit a row distance
// division, and per cell lit a column distance and a gain division (no gain
// division at zero distance); a skipped row is one step. The shared 64-step
// divider serves row height, row distance, column distance and gain quotient.
// Clear: one entry per cycle. Reset clears all MAX_CIRC_BINS*MAX_HEIGHT_BINS
// entries, busy high. The receiver cannot stall: done marks each result once.
`default_nettype none

module cylinder_light_splat_grid
	import cslg_pkg::*;
#(
	parameter int MAX_CIRC_BINS   = 64,
	parameter int MAX_HEIGHT_BINS = 64,
	parameter int MAX_REACH       = 7
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         cmd,
	input  wire  signed [31:0] pos_x,
	input  wire  signed [31:0] pos_y,
	input  wire  signed [31:0] pos_z,
	input  wire  [11:0]        cell_addr,
	output logic               done,
	output logic [31:0]        cell_value,
	output logic [7:0]         cells_lit,
	output logic               on_axis,
	input  wire                cfg_we,
	input  wire  [2:0]         cfg_index,
	input  wire  [31:0]        cfg_data
);

	localparam int NCW   = $clog2(MAX_CIRC_BINS + 1);
	localparam int NHW   = $clog2(MAX_HEIGHT_BINS + 1);
	localparam int DEPTH = MAX_CIRC_BINS * MAX_HEIGHT_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int YNW   = 33 + NHW;
	localparam int RWW   = YNW + 2;
	localparam int PW    = 32 + NHW;
	localparam int DHW   = YNW + 1;
	localparam int MW    = NCW + 16;
	localparam int AUW   = 17 + NCW;
	localparam int TW    = MW + 4;
	localparam int CVW   = NCW + 4;
	localparam int CW    = CORDIC_W;
	localparam int ACW   = ANGLE_W;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_COR   = 5'd3;
	localparam logic [4:0] S_ANG   = 5'd4;
	localparam logic [4:0] S_AU    = 5'd5;
	localparam logic [4:0] S_HDW   = 5'd6;
	localparam logic [4:0] S_NORM  = 5'd7;
	localparam logic [4:0] S_ROW   = 5'd8;
	localparam logic [4:0] S_DHM   = 5'd9;
	localparam logic [4:0] S_DHD   = 5'd10;
	localparam logic [4:0] S_DHW   = 5'd11;
	localparam logic [4:0] S_DC    = 5'd12;
	localparam logic [4:0] S_DCW   = 5'd13;
	localparam logic [4:0] S_SUM   = 5'd14;
	localparam logic [4:0] S_QW    = 5'd15;
	localparam logic [4:0] S_MRD   = 5'd16;
	localparam logic [4:0] S_MWR   = 5'd17;
	localparam logic [4:0] S_FIN   = 5'd18;

	// configuration registers
	logic [6:0]  circ_bins_q, height_bins_q;
	logic [31:0] wall_height_q, light_gain_q;
	logic [2:0]  reach_height_q, reach_circ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_bins_q    <= 7'd64;
			height_bins_q  <= 7'd64;
			wall_height_q  <= 32'd65536;
			light_gain_q   <= 32'd65536;
			reach_height_q <= 3'd1;
			reach_circ_q   <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CIRC_BINS:    circ_bins_q    <= cfg_data[6:0];
				REG_HEIGHT_BINS:  height_bins_q  <= cfg_data[6:0];
				REG_WALL_HEIGHT:  wall_height_q  <= cfg_data;
				REG_LIGHT_GAIN:   light_gain_q   <= cfg_data;
				REG_REACH_HEIGHT: reach_height_q <= cfg_data[2:0];
				REG_REACH_CIRC:   reach_circ_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// effective grid size, reach and height
	logic [NCW-1:0] nc;
	logic [NHW-1:0] nh;
	logic [2:0]     rc, rh;
	logic [31:0]    hgt;
	logic [MW-1:0]  m_c;

	always_comb begin
		if (circ_bins_q == 7'd0)
			nc = NCW'(1);
		else if (32'(circ_bins_q) > 32'(MAX_CIRC_BINS))
			nc = NCW'(MAX_CIRC_BINS);
		else
			nc = NCW'(circ_bins_q);
		if (height_bins_q == 7'd0)
			nh = NHW'(1);
		else if (32'(height_bins_q) > 32'(MAX_HEIGHT_BINS))
			nh = NHW'(MAX_HEIGHT_BINS);
		else
			nh = NHW'(height_bins_q);
		rc  = (32'(reach_circ_q) > 32'(MAX_REACH)) ? 3'(MAX_REACH) : reach_circ_q;
		rh  = (32'(reach_height_q) > 32'(MAX_REACH)) ? 3'(MAX_REACH) : reach_height_q;
		hgt = (wall_height_q == 32'd0) ? 32'd1 : wall_height_q;
		m_c = {nc, 16'd0};
	end

	// shared restoring divider, one quotient bit per cycle
	logic        dv_go;
	logic [63:0] dv_num, dv_den;
	logic [63:0] dv_rem_q, dv_quo_q, dv_den_q;
	logic [6:0]  dv_cnt_q;
	logic        dv_busy_q;
	logic [64:0] dv_sh, dv_diff;

	always_comb begin
		dv_sh   = {dv_rem_q, dv_quo_q[63]};
		dv_diff = dv_sh - {1'b0, dv_den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= 7'd0;
		end else if (dv_go) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= 7'd64;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 7'd1;
			if (dv_cnt_q == 7'd1)
				dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_go) begin
			dv_rem_q <= 64'd0;
			dv_quo_q <= dv_num;
			dv_den_q <= dv_den;
		end else if (dv_busy_q) begin
			if (!dv_diff[64]) begin
				dv_rem_q <= dv_diff[63:0];
				dv_quo_q <= {dv_quo_q[62:0], 1'b1};
			end else begin
				dv_rem_q <= dv_sh[63:0];
				dv_quo_q <= {dv_quo_q[62:0], 1'b0};
			end
		end
	end

	// light store: one write port, one registered read port
	logic [31:0]   mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd, mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// working registers
	logic [4:0]            state_q;
	logic                  clr_reply_q;
	logic [AW-1:0]         clr_cnt_q;
	logic                  addr_ok_q;
	logic signed [CW-1:0]  cx_q, cy_q;
	logic signed [ACW-1:0] acc_q;
	logic [4:0]            i_q;
	logic [16:0]           a_q;
	logic [AUW-1:0]        a_u_q;
	logic signed [YNW-1:0] y_nh_q;
	logic signed [RWW-1:0] row_q, row_end_q;
	logic [NHW-1:0]        rowi_q;
	logic signed [CVW-1:0] colv_q;
	logic signed [TW-1:0]  trv_q;
	logic [NCW-1:0]        col_start_q, col_q;
	logic [MW-1:0]         tr_start_q, tr_q;
	logic [PW-1:0]         dhp_q;
	logic [63:0]           dh_q, sqh_q;
	logic [33:0]           sqc_q;
	logic [31:0]           add_q;
	logic [AW-1:0]         idx_q;
	logic [3:0]            k_q;
	logic [7:0]            cnt_q;

	// combinational helpers
	logic                  accept;
	logic signed [YNW-1:0] y_nh_c;
	logic signed [CW-1:0]  px, pz, dx, dy;
	logic signed [ACW-1:0] at_s;
	logic signed [ACW:0]   acc_b;
	logic [24:0]           accn;
	logic [YNW-1:0]        ynh_mag;
	logic signed [RWW-1:0] qs, hb_c;
	logic signed [TW-1:0]  tr_init;
	logic                  col_lo, col_hi, tr_lo, tr_hi, row_ok;
	logic signed [DHW-1:0] dh_diff;
	logic [DHW-1:0]        dh_mag;
	logic [MW-1:0]         mtr, fold;
	logic [64:0]           s_wide;
	logic [63:0]           s_sat;
	logic [AW-1:0]         idx_c;
	logic [32:0]           sum_c;
	logic [MW:0]           tr_nx;

	always_comb begin
		accept  = start && (state_q == S_IDLE);
		y_nh_c  = pos_y * $signed({1'b0, nh});
		px      = CW'(pos_x);
		pz      = CW'(pos_z);
		dx      = cy_q >>> i_q;
		dy      = cx_q >>> i_q;
		at_s    = $signed(ACW'(atan_turn(i_q)));
		acc_b   = $signed({acc_q[ACW-1], acc_q}) + 27'sd8388608;
		if (acc_b < 0)
			accn = 25'd0;
		else if (acc_b > 27'sd16777216)
			accn = 25'd16777216;
		else
			accn = acc_b[24:0];
		ynh_mag = y_nh_q[YNW-1] ? YNW'(-y_nh_q) : YNW'(y_nh_q);
		qs      = $signed(RWW'(dv_quo_q[YNW-1:0]));
		hb_c    = y_nh_q[YNW-1] ? (-qs - $signed(RWW'(|dv_rem_q))) : qs;
		tr_init = -($signed(TW'({rc, 16'd0})) + $signed(TW'(a_u_q[15:0])));
		col_lo  = colv_q < 0;
		col_hi  = colv_q >= $signed(CVW'(nc));
		tr_lo   = trv_q < 0;
		tr_hi   = trv_q >= $signed(TW'(m_c));
		row_ok  = !row_q[RWW-1] && (row_q < $signed(RWW'(nh)));
		dh_diff = $signed(DHW'(dhp_q)) - $signed(DHW'(y_nh_q));
		dh_mag  = dh_diff[DHW-1] ? DHW'(-dh_diff) : DHW'(dh_diff);
		mtr     = m_c - tr_q;
		fold    = (mtr < tr_q) ? mtr : tr_q;
		s_wide  = {1'b0, sqh_q} + 65'(sqc_q);
		s_sat   = s_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_wide[63:0];
		idx_c   = AW'(col_q) + AW'(AW'(rowi_q) * AW'(nc));
		sum_c   = {1'b0, mem_rd_q} + {1'b0, add_q};
		tr_nx   = {1'b0, tr_q} + (MW + 1)'(65536);
	end

	// divider requests
	always_comb begin
		dv_go  = 1'b0;
		dv_num = 64'd0;
		dv_den = 64'd1;
		unique case (state_q)
			S_AU: begin
				dv_go  = 1'b1;
				dv_num = 64'(ynh_mag);
				dv_den = 64'(hgt);
			end
			S_DHD: begin
				dv_go  = 1'b1;
				dv_num = 64'(dh_mag);
				dv_den = 64'(nh);
			end
			S_DC: begin
				dv_go  = 1'b1;
				dv_num = 64'(fold);
				dv_den = 64'(nc);
			end
			S_SUM: begin
				dv_go  = (s_sat != 64'd0);
				dv_num = {light_gain_q, 32'd0};
				dv_den = s_sat;
			end
			default: ;
		endcase
	end

	// store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = sum_c[32] ? WORD_MAX : sum_c[31:0];
		mem_ra = (state_q == S_MRD) ? idx_c : AW'(cell_addr);
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = 32'd0;
		end else if (state_q == S_MWR) begin
			mem_we = 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_reply_q <= 1'b0;
			clr_cnt_q   <= '0;
			done        <= 1'b0;
			cell_value  <= 32'd0;
			cells_lit   <= 8'd0;
			on_axis     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
						if (clr_reply_q) begin
							done       <= 1'b1;
							cell_value <= 32'd0;
							cells_lit  <= 8'd0;
							on_axis    <= 1'b0;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_ADD: begin
								if (pos_x == 32'sd0 && pos_z == 32'sd0) begin
									done       <= 1'b1;
									cell_value <= 32'd0;
									cells_lit  <= 8'd0;
									on_axis    <= 1'b1;
								end else begin
									state_q <= S_COR;
								end
							end
							CMD_CLEAR: begin
								state_q     <= S_CLEAR;
								clr_reply_q <= 1'b1;
								clr_cnt_q   <= '0;
							end
							CMD_READ: state_q <= S_RD;
							default: begin
								done       <= 1'b1;
								cell_value <= 32'd0;
								cells_lit  <= 8'd0;
								on_axis    <= 1'b0;
							end
						endcase
					end
				end
				S_RD: begin
					state_q    <= S_IDLE;
					done       <= 1'b1;
					cell_value <= addr_ok_q ? mem_rd_q : 32'd0;
					cells_lit  <= 8'd0;
					on_axis    <= 1'b0;
				end
				S_COR: begin
					if (i_q == 5'(CORDIC_STEPS - 1))
						state_q <= S_ANG;
				end
				S_ANG:  state_q <= S_AU;
				S_AU:   state_q <= S_HDW;
				S_HDW: begin
					if (!dv_busy_q)
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (!col_lo && !col_hi && !tr_lo && !tr_hi)
						state_q <= S_ROW;
				end
				S_ROW: begin
					if (row_ok)
						state_q <= S_DHM;
					else if (row_q == row_end_q)
						state_q <= S_FIN;
				end
				S_DHM:  state_q <= S_DHD;
				S_DHD:  state_q <= S_DHW;
				S_DHW: begin
					if (!dv_busy_q)
						state_q <= S_DC;
				end
				S_DC:   state_q <= S_DCW;
				S_DCW: begin
					if (!dv_busy_q)
						state_q <= S_SUM;
				end
				S_SUM:  state_q <= (s_sat == 64'd0) ? S_MRD : S_QW;
				S_QW: begin
					if (!dv_busy_q)
						state_q <= S_MRD;
				end
				S_MRD:  state_q <= S_MWR;
				S_MWR: begin
					if (k_q == {rc, 1'b0})
						state_q <= (row_q == row_end_q) ? S_FIN : S_ROW;
					else
						state_q <= S_DC;
				end
				S_FIN: begin
					state_q    <= S_IDLE;
					done       <= 1'b1;
					cell_value <= 32'd0;
					cells_lit  <= cnt_q;
					on_axis    <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				addr_ok_q <= 32'(cell_addr) < 32'(DEPTH);
				y_nh_q    <= y_nh_c;
				i_q       <= 5'd0;
				cnt_q     <= 8'd0;
				// quarter-turn pre-rotation when the vector points backwards
				if (pos_z < 0) begin
					if (pos_x >= 0) begin
						cx_q  <= px;
						cy_q  <= -pz;
						acc_q <= ACW'(4194304);
					end else begin
						cx_q  <= -px;
						cy_q  <= pz;
						acc_q <= -$signed(ACW'(4194304));
					end
				end else begin
					cx_q  <= pz;
					cy_q  <= px;
					acc_q <= '0;
				end
			end
			S_COR: begin
				i_q <= i_q + 5'd1;
				if (cy_q > 0) begin
					cx_q  <= cx_q + dx;
					cy_q  <= cy_q - dy;
					acc_q <= acc_q + at_s;
				end else begin
					cx_q  <= cx_q - dx;
					cy_q  <= cy_q + dy;
					acc_q <= acc_q - at_s;
				end
			end
			S_ANG: a_q <= 17'((accn + 25'd128) >> 8);
			S_AU:  a_u_q <= AUW'(a_q) * AUW'(nc);
			S_HDW: begin
				if (!dv_busy_q) begin
					row_q     <= hb_c - $signed(RWW'(rh));
					row_end_q <= hb_c + $signed(RWW'(rh));
					colv_q    <= $signed(CVW'(a_u_q[AUW-1:16])) - $signed(CVW'(rc));
					trv_q     <= tr_init;
				end
			end
			S_NORM: begin
				// bring start column and turn offset into range
				if (col_lo)
					colv_q <= colv_q + $signed(CVW'(nc));
				else if (col_hi)
					colv_q <= colv_q - $signed(CVW'(nc));
				if (tr_lo)
					trv_q <= trv_q + $signed(TW'(m_c));
				else if (tr_hi)
					trv_q <= trv_q - $signed(TW'(m_c));
				col_start_q <= colv_q[NCW-1:0];
				tr_start_q  <= trv_q[MW-1:0];
			end
			S_ROW: begin
				rowi_q <= row_q[NHW-1:0];
				if (!row_ok && row_q != row_end_q)
					row_q <= row_q + RWW'(1);
			end
			S_DHM: dhp_q <= PW'(rowi_q) * PW'(hgt);
			S_DHW: begin
				if (!dv_busy_q) begin
					dh_q  <= dv_quo_q;
					col_q <= col_start_q;
					tr_q  <= tr_start_q;
					k_q   <= 4'd0;
				end
			end
			S_DCW: begin
				if (!dv_busy_q) begin
					sqh_q <= (dh_q > 64'(WORD_MAX)) ? 64'hFFFF_FFFF_FFFF_FFFF :
						64'(dh_q[31:0]) * 64'(dh_q[31:0]);
					sqc_q <= 34'(dv_quo_q[16:0]) * 34'(dv_quo_q[16:0]);
				end
			end
			S_SUM: begin
				if (s_sat == 64'd0)
					add_q <= WORD_MAX;
			end
			S_QW: begin
				if (!dv_busy_q)
					add_q <= (|dv_quo_q[63:32]) ? WORD_MAX : dv_quo_q[31:0];
			end
			S_MRD: idx_q <= idx_c;
			S_MWR: begin
				cnt_q <= cnt_q + 8'd1;
				if (k_q == {rc, 1'b0}) begin
					if (row_q != row_end_q)
						row_q <= row_q + RWW'(1);
				end else begin
					k_q   <= k_q + 4'd1;
					col_q <= (col_q == nc - NCW'(1)) ? NCW'(0) : col_q + NCW'(1);
					tr_q  <= (tr_nx >= {1'b0, m_c}) ? MW'(tr_nx - {1'b0, m_c}) : MW'(tr_nx);
				end
			end
			default: ;
		endcase
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_axis_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && on_axis) |-> (cells_lit == 8'd0 && cell_value == 32'd0))
		else $error("on-axis result carries data");

	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_READ) |-> ##2 done)
		else $error("read result late");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dv_go |-> !dv_busy_q)
		else $error("divider restarted while running");

endmodule

`default_nettype wire

### tb/sv/tb_cylinder_light_splat_grid.sv
// Self-checking testbench for cylinder_light_splat_grid: random and directed words
// against a built-in predictor of the angle, window walk and saturating light store.
// Depends on cslg_pkg and the cylinder_light_splat_grid RTL.
`timescale 1ns / 1ps

module tb_cylinder_light_splat_grid;
	import cslg_pkg::*;

	localparam int NC_MAX    = 64;
	localparam int NH_MAX    = 64;
	localparam int REACH_MAX = 7;
	localparam int DEPTH     = NC_MAX * NH_MAX;
	localparam int STALL_LIMIT = 200000;
	localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] cell_value;
		logic [7:0]  cells_lit;
		logic        on_axis;
	} grid_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         cmd = CMD_ADD;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic [11:0]        cell_addr = '0;
	logic               done;
	logic [31:0]        cell_value;
	logic [7:0]         cells_lit;
	logic               on_axis;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// predictor state
	logic [31:0] grid_model [DEPTH];
	logic [6:0]  m_circ_bins;
	logic [6:0]  m_height_bins;
	logic [31:0] m_wall_height;
	logic [31:0] m_light_gain;
	logic [2:0]  m_reach_height;
	logic [2:0]  m_reach_circ;

	grid_result_t pending_results[$];
	int  fail_count = 0;
	int  idle_pct = 0;
	int  quiet_cycles = 0;

	cylinder_light_splat_grid i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cell_addr(cell_addr),
		.done(done), .cell_value(cell_value), .cells_lit(cells_lit), .on_axis(on_axis),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp64(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if (n < 0 && q * d != n)
			q--;
		return q;
	endfunction

	// angle around y in Q0.16 of a turn, vector (z, x)
	function automatic longint turn_fraction(longint x, longint z);
		longint cx, cy, acc, t, dx, dy;
		cx = z;
		cy = x;
		acc = 0;
		if (cx < 0) begin
			t = cx;
			if (cy >= 0) begin
				cx = cy; cy = -t; acc = 4194304;
			end else begin
				cx = -cy; cy = t; acc = -4194304;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx; cy -= dy; acc += longint'(atan_turn(5'(i)));
			end else begin
				cx -= dx; cy += dy; acc -= longint'(atan_turn(5'(i)));
			end
		end
		acc = clamp64(acc + 8388608, 0, 16777216);
		return (acc + 128) >>> 8;
	endfunction

	function automatic logic [31:0] splat_light(longint unsigned dh, longint unsigned dc);
		longint unsigned s, s2, q;
		if (dh > 64'hFFFF_FFFF)
			s = U64_MAX;
		else
			s = dh * dh;
		s2 = dc * dc;
		s = (s > U64_MAX - s2) ? U64_MAX : s + s2;
		if (s == 0)
			return WORD_MAX;
		q = ({32'd0, m_light_gain} << 32) / s;
		return q > 64'hFFFF_FFFF ? WORD_MAX : q[31:0];
	endfunction

	function automatic int splat_particle(longint x, longint y, longint z);
		longint nc, nh, rc, rh, hgt, a, a_u, m, cb, hb, dh_u, col, r, idx;
		longint unsigned dh, dc;
		logic [31:0] add, cur;
		int count;
		nc = clamp64(m_circ_bins, 1, NC_MAX);
		nh = clamp64(m_height_bins, 1, NH_MAX);
		rc = clamp64(m_reach_circ, 0, REACH_MAX);
		rh = clamp64(m_reach_height, 0, REACH_MAX);
		hgt = (m_wall_height != 0) ? longint'(m_wall_height) : 1;
		a = turn_fraction(x, z);
		a_u = a * nc;
		m = 65536 * nc;
		cb = a_u >>> 16;
		hb = floor_quot(y * nh, hgt);
		count = 0;
		for (longint row = hb - rh; row <= hb + rh; row++) begin
			if (row < 0 || row >= nh)
				continue;
			dh_u = row * hgt - y * nh;
			if (dh_u < 0)
				dh_u = -dh_u;
			dh = longint'(dh_u / nh);
			for (longint off = -rc; off <= rc; off++) begin
				col = ((cb + off) % nc + nc) % nc;
				r = ((cb + off) * 65536 - a_u) % m;
				idx = col + row * nc;
				if (r < 0)
					r += m;
				if (m - r < r)
					r = m - r;
				dc = longint'(r / nc);
				add = splat_light(dh, dc);
				cur = grid_model[idx];
				grid_model[idx] = (cur > WORD_MAX - add) ? WORD_MAX : cur + add;
				count++;
			end
		end
		return count;
	endfunction

	function automatic grid_result_t predict_grid_word(logic [1:0] c, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic [11:0] addr);
		grid_result_t res;
		int n;
		res = '0;
		case (c)
			CMD_ADD: begin
				if (x == 0 && z == 0)
					res.on_axis = 1'b1;
				else begin
					n = splat_particle(longint'(x), longint'(y), longint'(z));
					res.cells_lit = n[7:0];
				end
			end
			CMD_CLEAR: begin
				foreach (grid_model[i])
					grid_model[i] = '0;
			end
			CMD_READ: res.cell_value = grid_model[addr];
			default: ;
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin
		grid_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word");
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (cell_value !== exp_res.cell_value) begin
					$error("cell_value: expected %h, got %h", exp_res.cell_value, cell_value);
					fail_count++;
				end
				if (cells_lit !== exp_res.cells_lit) begin
					$error("cells_lit: expected %0d, got %0d", exp_res.cells_lit, cells_lit);
					fail_count++;
				end
				if (on_axis !== exp_res.on_axis) begin
					$error("on_axis: expected %b, got %b", exp_res.on_axis, on_axis);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic hold_off(int n);
		@(negedge clk);
		start = 1'b0;
		cmd = 2'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// start is left high after accept; the next send or pause lowers or reuses it
	task automatic send_word(logic [1:0] c, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [11:0] addr);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			hold_off($urandom_range(1, 12));
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		pos_x = x;
		pos_y = y;
		pos_z = z;
		cell_addr = addr;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_results.insert(pending_results.size(), predict_grid_word(c, x, y, z, addr));
	endtask

	task automatic drain();
		hold_off(1);
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_CIRC_BINS:    m_circ_bins = val[6:0];
			REG_HEIGHT_BINS:  m_height_bins = val[6:0];
			REG_WALL_HEIGHT:  m_wall_height = val;
			REG_LIGHT_GAIN:   m_light_gain = val;
			REG_REACH_HEIGHT: m_reach_height = val[2:0];
			REG_REACH_CIRC:   m_reach_circ = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(int nc, int nh, logic [31:0] hgt, logic [31:0] gain, int rh, int rc);
		write_reg(REG_CIRC_BINS, nc);
		write_reg(REG_HEIGHT_BINS, nh);
		write_reg(REG_WALL_HEIGHT, hgt);
		write_reg(REG_LIGHT_GAIN, gain);
		write_reg(REG_REACH_HEIGHT, rh);
		write_reg(REG_REACH_CIRC, rc);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 65535))) - 32768;
			default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
		endcase
	endfunction

	// height mostly inside the wall so the window lands on the grid
	function automatic logic signed [31:0] rand_height();
		longint hgt;
		hgt = (m_wall_height != 0) ? longint'(m_wall_height) : 1;
		if ($urandom_range(9) < 8)
			return 32'(longint'($urandom) % hgt);
		return $urandom;
	endfunction

	task automatic random_word();
		logic signed [31:0] x, z;
		int pick;
		pick = $urandom_range(99);
		x = rand_coord();
		z = rand_coord();
		if (pick < 3)
			x = 0;
		if (pick < 2)
			z = 0;
		if (pick < 58)
			send_word(CMD_ADD, x, rand_height(), z, 12'($urandom));
		else if (pick < 92)
			send_word(CMD_READ, $urandom, $urandom, $urandom, 12'($urandom));
		else if (pick < 94)
			send_word(CMD_CLEAR, $urandom, $urandom, $urandom, 12'($urandom));
		else
			send_word(2'd3, $urandom, $urandom, $urandom, 12'($urandom));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_defaults();
		send_word(CMD_READ, 0, 0, 0, 12'd0);
		send_word(CMD_READ, 0, 0, 0, 12'hFFF);
		send_word(CMD_ADD, 0, 32'sh8000, 0, 12'd0);                // on the axis
		send_word(CMD_ADD, 32'sh10000, 32'sh8000, 32'sh10000, 12'd0);
		send_word(CMD_ADD, 0, 0, 32'sh10000, 12'd0);                // zero distance
		send_word(CMD_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 12'd0);
		send_word(CMD_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 12'd0);
		send_word(CMD_ADD, -32'sh10000, -32'sh100, 32'sh10, 12'd0); // row below grid
		send_word(CMD_ADD, 32'sh10, 32'sh10000, -32'sh10000, 12'd0); // row on top edge
		send_word(CMD_ADD, -32'sh1, 32'sh4000, -32'sh10000, 12'd0);
		send_word(2'd3, -1, -1, -1, 12'hFFF);
		for (int i = 0; i < 4; i++)
			send_word(CMD_READ, 0, 0, 0, 12'(i * 64 + i));
		send_word(CMD_CLEAR, 0, 0, 0, 12'd0);
		send_word(CMD_READ, 0, 0, 0, 12'd64);
	endtask

	task automatic test_register_extremes();
		// bins of 0 act as one cell, window wraps onto the same cell
		set_grid(0, 0, 0, 32'hFFFF_FFFF, 1, 2);
		send_word(CMD_ADD, 32'sh100, 0, 32'sh100, 12'd0);
		send_word(CMD_ADD, 32'sh100, 0, 32'sh100, 12'd0);
		send_word(CMD_READ, 0, 0, 0, 12'd0);
		// oversized bins clamp, tall wall, no gain
		set_grid(127, 127, 32'hFFFF_FFFF, 0, 0, 0);
		send_word(CMD_ADD, -32'sh3000, 32'sh7FFF0000, 32'sh5000, 12'd0);
		send_word(CMD_READ, 0, 0, 0, 12'hFFF);
		// widest window, slow so kept short
		set_grid(64, 64, 32'sh10000, 32'h0001_0000, 7, 7);
		for (int i = 0; i < 3; i++)
			send_word(CMD_ADD, rand_coord(), rand_height(), rand_coord(), 12'd0);
		set_grid(1, 1, 1, 32'h8000_0000, 7, 0);
		send_word(CMD_ADD, 32'sh1, 32'sh0, 32'sh1, 12'd0);
		send_word(CMD_READ, 0, 0, 0, 12'd0);
		send_word(CMD_CLEAR, 0, 0, 0, 12'd0);
	endtask

	task automatic test_random(int n_words, int pct);
		int nc, nh, rh, rc;
		logic [31:0] hgt, gain;
		idle_pct = pct;
		for (int i = 0; i < n_words; i++) begin
			if (i % 60 == 0) begin
				nc = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 64);
				nh = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 64);
				hgt = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 32'h20_0000);
				gain = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h4_0000);
				rh = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
				rc = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
				set_grid(nc, nh, hgt, gain, rh, rc);
			end
			random_word();
		end
	endtask

	initial begin
		foreach (grid_model[i])
			grid_model[i] = '0;
		m_circ_bins = 7'd64;
		m_height_bins = 7'd64;
		m_wall_height = 32'd65536;
		m_light_gain = 32'd65536;
		m_reach_height = 3'd1;
		m_reach_circ = 3'd1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_register_extremes();
		test_random(480, 0);
		test_random(480, 80);
		test_random(480, 32);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/core/cslg_pkg.sv
rtl/core/cylinder_light_splat_grid.sv
tb/sv/tb_cylinder_light_splat_grid.sv
